// File: sv/rgbe_to_rgba_half_defines.svh
// Assertion macros shared by the conversion block.
`ifndef RGBE_TO_RGBA_HALF_DEFINES_SVH
`define RGBE_TO_RGBA_HALF_DEFINES_SVH
// Implication checked on every rising clock edge, off during reset.
`define RTH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, off during reset.
`define RTH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/rth_pkg.sv
// Package: constants, types and the byte/255 function for RGBE to half conversion.
package rth_pkg;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned HALF_W = 16;
	localparam int unsigned SIG_W = 24;
	localparam int unsigned RGBE_BIAS = 128;
	localparam logic [HALF_W-1:0] HALF_ONE = 16'h3C00;
	localparam logic [HALF_W-1:0] HALF_INF = 16'h7C00;

	typedef struct packed {
		logic [SIG_W-1:0] sig;
		logic [3:0] shft;
	} quot_t;

	// Correctly rounded float32 of b/255: sig in [2^23,2^24) for nonzero b, value = sig*2^(-shft-23)
	// i.e. exponent = -shft (relative to 2^0 with sig scaled by 2^-23).
	function automatic quot_t quot255(input logic [BYTE_W-1:0] b);
		quot_t r;
		logic [39:0] num;
		logic [39:0] q;
		logic [39:0] rm;
		int unsigned s;
		int unsigned sel;
		r = '0;
		sel = 31;
		for (s = 31; s >= 23; s--) begin
			num = 40'(b) << s;
			q = num / 40'd255;
			if (q >= 40'h800000) sel = s;
		end
		num = 40'(b) << sel;
		q = num / 40'd255;
		rm = num % 40'd255;
		if (rm * 40'd2 > 40'd255) q = q + 40'd1;
		r.shft = 4'(sel - 23);
		if (q >= 40'h1000000) begin
			q = q >> 1;
			r.shft = r.shft - 4'd1;
		end
		r.sig = q[SIG_W-1:0];
		return r;
	endfunction
endpackage

// File: sv/rth_if.sv
// Valid/ready channel interface with a generic payload.
interface rth_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/rth_chan.sv
// One colour channel: byte lookup, exponent math, rounding to half, three stages.
module rth_chan import rth_pkg::*; (
	input logic clk,
	input logic en,
	input logic [BYTE_W-1:0] b,
	input logic [BYTE_W-1:0] e,
	output logic [HALF_W-1:0] h
);
	quot_t qtab [2**BYTE_W];
	quot_t q_s1;
	logic zero_s1;
	logic [BYTE_W-1:0] e_s1;
	logic [SIG_W-1:0] sig_s2;
	logic [9:0] ue_s2;
	logic zero_s2;
	logic [9:0] ue;
	logic inf_c, tiny_c;
	logic [4:0] shift;
	logic [HALF_W-1:0] base, hv, res;
	logic [SIG_W-1:0] rem, hw;
	logic [SIG_W:0] hsum;

	// constant table of byte/255, folded at elaboration
	for (genvar gi = 0; gi < 2**BYTE_W; gi++) begin : g_qtab
		assign qtab[gi] = quot255(BYTE_W'(gi));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= qtab[b];
			zero_s1 <= (b == '0) || (e == '0);
			e_s1 <= e;
			sig_s2 <= q_s1.sig;
			ue_s2 <= 10'(e_s1) - 10'(RGBE_BIAS) - 10'(q_s1.shft);
			zero_s2 <= zero_s1;
			h <= res;
		end
	end

	always_comb begin
		ue = ue_s2;
		inf_c = !ue[9] && (ue > 10'd15);
		tiny_c = ue[9] && (ue < 10'h3F2 - 10'd11);
		if (!ue[9] || ue >= 10'h3F2) begin
			base = HALF_W'(5'(ue + 10'd14)) << 10;
			shift = 5'd13;
		end else begin
			base = '0;
			shift = 5'(10'd13 + (10'h3F2 - ue));
		end
		if (tiny_c) shift = 5'd25;
		hv = HALF_W'(sig_s2 >> shift);
		rem = sig_s2 & ((SIG_W'(1) << shift) - SIG_W'(1));
		hw = SIG_W'(1) << (shift - 5'd1);
		hsum = (SIG_W+1)'(hv);
		if (rem > hw || (rem == hw && hv[0])) hsum = hsum + (SIG_W+1)'(1);
		res = base + HALF_W'(hsum);
		if (res >= HALF_INF || inf_c) res = HALF_INF;
		if (zero_s2 || tiny_c) res = '0;
	end
endmodule

// File: sv/rgbe_to_rgba_half.sv
// Top level: RGBE texel stream to four binary16 words per texel.
// channel | role | payload
// in_ch   | sink   | red_byte, green_byte, blue_byte, shared_exponent
// out_ch  | source | red_half, green_half, blue_half, alpha_half
// One texel per cycle while the output is not stalled; texels pass through the channel pipeline.
// Reset clears the stage valid bits only.
// A stall at the output freezes every stage; ready is open while the
// last stage is empty or being drained.
`include "rgbe_to_rgba_half_defines.svh"
module rgbe_to_rgba_half import rth_pkg::*; (
	input logic clk,
	input logic arst_n,
	rth_if.sink in_ch,
	rth_if.source out_ch
);
	logic [2:0] vld_q;
	logic adv;
	assign adv = !vld_q[2] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[1:0], in_ch.valid};
		end
	end

	rth_chan u_r (.clk, .en(adv), .b(in_ch.data.red_byte),
		.e(in_ch.data.shared_exponent), .h(out_ch.data.red_half));
	rth_chan u_g (.clk, .en(adv), .b(in_ch.data.green_byte),
		.e(in_ch.data.shared_exponent), .h(out_ch.data.green_half));
	rth_chan u_b (.clk, .en(adv), .b(in_ch.data.blue_byte),
		.e(in_ch.data.shared_exponent), .h(out_ch.data.blue_half));
	assign out_ch.data.alpha_half = HALF_ONE;
	assign out_ch.valid = vld_q[2];

	`RTH_ASSERT_NXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "beat dropped")
	`RTH_ASSERT_IMP(a_rdy, clk, arst_n, !out_ch.valid, in_ch.ready, "ready low with empty output")
	`RTH_ASSERT_IMP(a_alpha, clk, arst_n, out_ch.valid, out_ch.data.alpha_half == HALF_ONE, "alpha")
endmodule

// File: dv/tb_rth_types.sv
// Beat payload types for the RGBE texel and the half-float pixel channels.
`timescale 1ns / 1ps
package tb_rth_types;
	import rth_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] red_byte;
		logic [BYTE_W-1:0] green_byte;
		logic [BYTE_W-1:0] blue_byte;
		logic [BYTE_W-1:0] shared_exponent;
	} texel_t;

	typedef struct packed {
		logic [HALF_W-1:0] red_half;
		logic [HALF_W-1:0] green_half;
		logic [HALF_W-1:0] blue_half;
		logic [HALF_W-1:0] alpha_half;
	} pixel_t;
endpackage

// File: dv/rth_checker.sv
// Checker: predicts half-float pixels from accepted texels and compares them in order.
`timescale 1ns / 1ps
module rth_checker import rth_pkg::*, tb_rth_types::*; (
	input logic clk,
	input logic arst_n,
	rth_if in_mon,
	rth_if out_mon,
	output int unsigned fail_count,
	output int unsigned pending
);
	pixel_t pixel_q[$];

	function automatic logic [HALF_W-1:0] byte_to_half(logic [7:0] mant, logic [7:0] expo);
		longint unsigned num;
		longint unsigned quo;
		longint unsigned rem;
		longint unsigned low;
		longint unsigned mid;
		longint unsigned hv;
		longint unsigned base;
		int s;
		int ex;
		int ue;
		int shift;
		if (mant == 0 || expo == 0) return '0;
		for (s = 23; s <= 31; s++) begin
			num = longint'(mant) << s;
			quo = num / 255;
			if (quo >= (64'd1 << 23)) break;
		end
		if (s > 31) s = 31;
		rem = num % 255;
		ex = 23 - s;
		if (rem * 2 > 255) quo++;
		if (quo >= (64'd1 << 24)) begin
			quo = quo >> 1;
			ex++;
		end
		ue = ex + int'(expo) - int'(RGBE_BIAS);
		if (ue > 15) return HALF_INF;
		if (ue >= -14) begin
			base = longint'(ue + 14) << 10;
			shift = 13;
		end else begin
			base = 0;
			shift = 13 + (-14 - ue);
		end
		if (shift > 25) return '0;
		hv = quo >> shift;
		low = quo & ((64'd1 << shift) - 1);
		mid = 64'd1 << (shift - 1);
		if (low > mid || (low == mid && hv[0])) hv++;
		hv = base + hv;
		if (hv >= HALF_INF) return HALF_INF;
		return hv[15:0];
	endfunction

	function automatic pixel_t predict_pixel(texel_t t);
		pixel_t p;
		p.red_half = byte_to_half(t.red_byte, t.shared_exponent);
		p.green_half = byte_to_half(t.green_byte, t.shared_exponent);
		p.blue_half = byte_to_half(t.blue_byte, t.shared_exponent);
		p.alpha_half = HALF_ONE;
		return p;
	endfunction

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		pixel_t exp_px;
		pixel_t got;
		if (arst_n) begin
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.data;
				if (pixel_q.size() == 0) begin
					$error("unexpected pixel beat %h", got);
					fail_count++;
				end else begin
					exp_px = pixel_q.pop_front();
					if (got.red_half !== exp_px.red_half) begin
						$error("red_half exp %h got %h", exp_px.red_half, got.red_half);
						fail_count++;
					end
					if (got.green_half !== exp_px.green_half) begin
						$error("green_half exp %h got %h", exp_px.green_half, got.green_half);
						fail_count++;
					end
					if (got.blue_half !== exp_px.blue_half) begin
						$error("blue_half exp %h got %h", exp_px.blue_half, got.blue_half);
						fail_count++;
					end
					if (got.alpha_half !== exp_px.alpha_half) begin
						$error("alpha_half exp %h got %h", exp_px.alpha_half, got.alpha_half);
						fail_count++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready) pixel_q.push_back(predict_pixel(in_mon.data));
		end
		pending = unsigned'(pixel_q.size());
	end
endmodule

// File: dv/tb_rgbe_to_rgba_half.sv
// Testbench top: texel stimulus, output back-pressure, watchdog and verdict.
`timescale 1ns / 1ps
module tb_rgbe_to_rgba_half;
	import rth_pkg::*;
	import tb_rth_types::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic clk = 0;
	logic arst_n;
	bit busy_stream = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned fail_count;
	int unsigned pending;

	rth_if #(.payload_t(texel_t)) in_ch (clk);
	rth_if #(.payload_t(pixel_t)) out_ch (clk);

	rgbe_to_rgba_half DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	rth_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		arst_n <= 1'b0;
	end

	always @(posedge clk) begin
		int unsigned n;
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
				if (out_ch.valid && out_ch.ready && !busy_stream) begin
					n = $urandom_range(0, 5);
					if (n > 0) begin
						stall_left <= n - 1;
						out_ch.ready <= 0;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rgbe_to_rgba_half test failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_texel(texel_t t);
		int unsigned gap;
		gap = busy_stream ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= t;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_bytes(int r, int g, int b, int e);
		texel_t t;
		t.red_byte = 8'(r);
		t.green_byte = 8'(g);
		t.blue_byte = 8'(b);
		t.shared_exponent = 8'(e);
		send_texel(t);
	endtask

	initial begin
		int unsigned e;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// corners: black, zero bytes, overflow, underflow, subnormal edge
		send_bytes(255, 128, 1, 0);
		send_bytes(0, 0, 0, 128);
		send_bytes(255, 255, 255, 128);
		send_bytes(1, 2, 3, 128);
		send_bytes(255, 128, 1, 255);
		send_bytes(255, 128, 1, 144);
		send_bytes(255, 128, 1, 143);
		send_bytes(255, 254, 1, 142);
		send_bytes(255, 128, 1, 1);
		send_bytes(255, 128, 1, 114);
		send_bytes(255, 128, 1, 113);
		send_bytes(255, 128, 1, 104);
		send_bytes(255, 128, 1, 103);
		send_bytes(255, 128, 1, 102);
		send_bytes(1, 170, 85, 110);
		send_bytes(0, 255, 0, 129);
		send_bytes(127, 64, 200, 129);

		for (int i = 0; i < 450; i++) begin
			if (i % 100 == 50) busy_stream = ~busy_stream;
			if (i == 220) begin
				in_ch.valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: e = $urandom_range(0, 255);
				1: e = $urandom_range(98, 116);
				2: e = $urandom_range(138, 146);
				default: e = $urandom_range(112, 144);
			endcase
			send_bytes($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), e);
		end
		in_ch.valid <= 0;
		busy_stream = 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("rgbe_to_rgba_half test passed");
		else
			$display("rgbe_to_rgba_half test failed");
		$finish;
	end
endmodule
